/* rtl/uept_pkg.sv */
package uept_pkg;

   localparam int CAPTURE_BITS = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int WIDTH_BITS = 18;
   localparam int PERIOD_BITS = 17;
   localparam int LIMIT_BITS = 2;
   localparam int DIST_BITS = 19;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 18;

   // width * 17 fits in 23 bits; dividing by ten is a multiply by
   // ceil(2^27 / 10) followed by a 27-bit right shift, exact for 23-bit values.
   localparam int SCALED_BITS = 23;
   localparam int RECIP_BITS = 24;
   localparam int DIST_SHIFT = 27;
   localparam logic [RECIP_BITS-1:0] DIST_RECIP = 24'd13421773;

   localparam logic [1:0] OP_OVERFLOW = 2'd0;
   localparam logic [1:0] OP_RISE = 2'd1;
   localparam logic [1:0] OP_FALL = 2'd2;
   localparam logic [1:0] OP_IDLE = 2'd3;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_VALID = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMER_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVERFLOW_LIMIT = 2'd2;

   localparam logic [PERIOD_BITS-1:0] TIMER_PERIOD_RST = 17'd65536;
   localparam logic [WIDTH_BITS-1:0] RANGE_LIMIT_RST = 18'd38000;
   localparam logic [LIMIT_BITS-1:0] OVERFLOW_LIMIT_RST = 2'd2;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [CAPTURE_BITS-1:0] capture_count;
   } req_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] echo_width;
      logic [1:0]            distance_status;
      logic [DIST_BITS-1:0]  distance_centi_cm;
      logic                  armed;
   } rsp_type;

   // Measurement state as it stands after the latest transfer.
   typedef struct packed {
      logic [WIDTH_BITS-1:0] width;
      logic                  armed;
   } snap_type;

endpackage

/* rtl/uept_result.sv */
module uept_result (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           snap_valid,
   output logic                           snap_stall,
   input  uept_pkg::snap_type             snap,
   input  logic [uept_pkg::WIDTH_BITS-1:0] range_limit,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output uept_pkg::rsp_type              rsp_data
);
   import uept_pkg::*;

   logic                    s2_valid_ff;
   logic                    s2_valid_in;
   logic [WIDTH_BITS-1:0]   s2_width_ff;
   logic [1:0]              s2_status_ff;
   logic [1:0]              status_in;
   logic [SCALED_BITS-1:0]  s2_scaled_ff;
   logic [SCALED_BITS-1:0]  scaled_in;
   logic                    s2_armed_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;
   logic [SCALED_BITS+RECIP_BITS-1:0] dist_prod;
   logic                    out_move;
   logic                    s2_move;

   assign out_move = !rsp_valid_ff || !rsp_stall;
   assign s2_move = !s2_valid_ff || out_move;
   assign snap_stall = !s2_move;

   always_comb begin
      if (snap.width == '0) begin
         status_in = STATUS_NONE;
      end else if (snap.width > range_limit) begin
         status_in = STATUS_RANGE;
      end else begin
         status_in = STATUS_VALID;
      end
      scaled_in = (SCALED_BITS'(snap.width) << 4) + SCALED_BITS'(snap.width);
      s2_valid_in = s2_move ? snap_valid : s2_valid_ff;
   end

   always_comb begin
      dist_prod = (SCALED_BITS+RECIP_BITS)'(s2_scaled_ff)
                * (SCALED_BITS+RECIP_BITS)'(DIST_RECIP);
      rsp_data_in.echo_width = s2_width_ff;
      rsp_data_in.distance_status = s2_status_ff;
      rsp_data_in.armed = s2_armed_ff;
      if (s2_status_ff == STATUS_VALID) begin
         rsp_data_in.distance_centi_cm = dist_prod[DIST_SHIFT +: DIST_BITS];
      end else begin
         rsp_data_in.distance_centi_cm = '0;
      end
      rsp_valid_in = out_move ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move && snap_valid) begin
         s2_width_ff <= snap.width;
         s2_status_ff <= status_in;
         s2_scaled_ff <= scaled_in;
         s2_armed_ff <= snap.armed;
      end
      if (out_move && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_none_iff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.echo_width == '0)
                        == (rsp_data_ff.distance_status == STATUS_NONE)))
      else $error("status none does not match a zero width");

   a_dist_only_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.distance_status != STATUS_VALID)
      |-> (rsp_data_ff.distance_centi_cm == '0))
      else $error("distance reported without a valid status");

   a_valid_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.distance_status == STATUS_VALID)
      |-> (rsp_data_ff.echo_width <= range_limit))
      else $error("valid status on a width beyond the range limit");

endmodule

/* rtl/ultrasonic_echo_pulse_timer_unit.sv */
// rsp_valid rises once the event transfer on req has passed the state registers,
// the s2 stage registers and the output register.
// Throughput: one event per cycle unless req_stall; the result path holds up
// to three items, so two more events are taken while a result waits on rsp_stall.
// Reset (synchronous) clears the measurement state and the pipeline and
// loads the register defaults: period 65536, range limit 38000, overflow limit 2.
module ultrasonic_echo_pulse_timer_unit #(
   parameter int COUNT_BITS = uept_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  uept_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output uept_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [uept_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [uept_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import uept_pkg::*;

   localparam int CapBits = (COUNT_BITS < CAPTURE_BITS) ? COUNT_BITS : CAPTURE_BITS;

   logic [PERIOD_BITS-1:0] timer_period_ff;
   logic [WIDTH_BITS-1:0]  range_limit_ff;
   logic [LIMIT_BITS-1:0]  overflow_limit_ff;

   logic                   busy_ff;
   logic                   busy_in;
   logic [LIMIT_BITS-1:0]  ovf_ff;
   logic [LIMIT_BITS-1:0]  ovf_in;
   logic [CapBits-1:0]     rise_ff;
   logic [CapBits-1:0]     rise_in;
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [WIDTH_BITS-1:0]  width_in;
   logic                   snap_valid_ff;
   logic                   snap_valid_in;

   logic                   snap_stall;
   logic                   req_accept;
   logic [CapBits-1:0]     cap;
   logic [LIMIT_BITS:0]    ovf_next;
   logic [WIDTH_BITS:0]    ovf_span;
   logic [WIDTH_BITS-1:0]  fall_width;
   snap_type               snap;

   assign req_stall = snap_valid_ff && snap_stall;
   assign req_accept = req_valid && !req_stall;
   assign cap = req_data.capture_count[CapBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_period_ff <= TIMER_PERIOD_RST;
         range_limit_ff <= RANGE_LIMIT_RST;
         overflow_limit_ff <= OVERFLOW_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMER_PERIOD: begin
               timer_period_ff <= csr_wdata[PERIOD_BITS-1:0];
            end
            CSR_RANGE_LIMIT: begin
               range_limit_ff <= csr_wdata[WIDTH_BITS-1:0];
            end
            CSR_OVERFLOW_LIMIT: begin
               overflow_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ovf_next = {1'b0, ovf_ff} + (LIMIT_BITS+1)'(busy_ff);
      // The width is kept modulo 2^18, so only the low bits of the span matter.
      ovf_span = (WIDTH_BITS+1)'(ovf_ff) * (WIDTH_BITS+1)'(timer_period_ff);
      fall_width = ovf_span[WIDTH_BITS-1:0] + WIDTH_BITS'(cap) - WIDTH_BITS'(rise_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      ovf_in = ovf_ff;
      rise_in = rise_ff;
      width_in = width_ff;
      if (req_accept) begin
         case (req_data.opcode)
            OP_OVERFLOW: begin
               if (ovf_next > {1'b0, overflow_limit_ff}) begin
                  busy_in = 1'b0;
                  ovf_in = '0;
                  rise_in = '0;
                  width_in = '0;
               end else begin
                  ovf_in = ovf_next[LIMIT_BITS-1:0];
               end
            end
            OP_RISE: begin
               rise_in = cap;
               busy_in = 1'b1;
            end
            OP_FALL: begin
               if (busy_ff) begin
                  width_in = fall_width;
                  busy_in = 1'b0;
                  ovf_in = '0;
               end else begin
                  busy_in = 1'b0;
                  ovf_in = '0;
                  rise_in = '0;
                  width_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (req_accept) begin
         snap_valid_in = 1'b1;
      end else begin
         snap_valid_in = snap_valid_ff && snap_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ovf_ff <= '0;
         rise_ff <= '0;
         width_ff <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ovf_ff <= ovf_in;
         rise_ff <= rise_in;
         width_ff <= width_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // The state registers hold still while their snapshot is stalled, since
   // no new transfer can be taken then.
   assign snap.width = width_ff;
   assign snap.armed = busy_ff;

   uept_result u_result (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid_ff),
      .snap_stall  (snap_stall),
      .snap        (snap),
      .range_limit (range_limit_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   a_idle_no_ovf: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (ovf_ff == '0))
      else $error("overflow count held while not armed");

   a_fall_disarms: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.opcode == OP_FALL) |=> !busy_ff && (ovf_ff == '0))
      else $error("falling edge left the measurement armed");

   a_rise_arms: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.opcode == OP_RISE)
      |=> busy_ff && (rise_ff == $past(req_data.capture_count[CapBits-1:0])))
      else $error("rising edge did not arm with its capture count");

endmodule

/* verif/tb.sv */
module tb;
   import uept_pkg::*;

   // Tracks the echo measurement as the block should see it and holds the
   // results that are still owed on the rsp channel.
   class echo_scoreboard;
      logic [PERIOD_BITS-1:0]  period;
      logic [WIDTH_BITS-1:0]   range_limit;
      logic [LIMIT_BITS-1:0]   ovf_limit;
      bit                      armed;
      logic [LIMIT_BITS-1:0]   ovf_seen;
      logic [CAPTURE_BITS-1:0] rise_mark;
      logic [WIDTH_BITS-1:0]   width_held;
      rsp_type                 pending[$];
      int                      fails;
      int                      checked;
      int                      status_seen[3];

      function new();
         period = TIMER_PERIOD_RST;
         range_limit = RANGE_LIMIT_RST;
         ovf_limit = OVERFLOW_LIMIT_RST;
         clear_measure();
      endfunction

      function void clear_measure();
         armed = 1'b0;
         ovf_seen = '0;
         rise_mark = '0;
         width_held = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_TIMER_PERIOD: period = value[PERIOD_BITS-1:0];
            CSR_RANGE_LIMIT: range_limit = value[WIDTH_BITS-1:0];
            CSR_OVERFLOW_LIMIT: ovf_limit = value[LIMIT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_event(req_type ev);
         int          ovf_next;
         logic [63:0] span;
         int unsigned scaled;
         rsp_type     want;
         case (ev.opcode)
            OP_OVERFLOW: begin
               ovf_next = int'(ovf_seen) + int'(armed);
               if (ovf_next > int'(ovf_limit)) begin
                  clear_measure();
               end else begin
                  ovf_seen = ovf_next[LIMIT_BITS-1:0];
               end
            end
            OP_RISE: begin
               rise_mark = ev.capture_count;
               armed = 1'b1;
            end
            OP_FALL: begin
               if (armed) begin
                  span = 64'(ovf_seen) * 64'(period) + 64'(ev.capture_count) - 64'(rise_mark);
                  width_held = span[WIDTH_BITS-1:0];
                  armed = 1'b0;
                  ovf_seen = '0;
               end else begin
                  clear_measure();
               end
            end
            default: ;
         endcase
         want.echo_width = width_held;
         want.distance_centi_cm = '0;
         want.armed = armed;
         if (width_held == '0) begin
            want.distance_status = STATUS_NONE;
         end else if (width_held > range_limit) begin
            want.distance_status = STATUS_RANGE;
         end else begin
            want.distance_status = STATUS_VALID;
            scaled = 32'(width_held) * 32'd17 / 32'd10;
            want.distance_centi_cm = scaled[DIST_BITS-1:0];
         end
         status_seen[want.distance_status]++;
         pending.push_back(want);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         fails++;
         $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("result with no event pending", 1, 0);
            return;
         end
         want = pending.pop_front();
         if (got.echo_width !== want.echo_width)
            report_mismatch("echo_width", got.echo_width, want.echo_width);
         if (got.distance_status !== want.distance_status)
            report_mismatch("distance_status", got.distance_status, want.distance_status);
         if (got.distance_centi_cm !== want.distance_centi_cm)
            report_mismatch("distance_centi_cm", got.distance_centi_cm,
                            want.distance_centi_cm);
         if (got.armed !== want.armed)
            report_mismatch("armed", got.armed, want.armed);
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   echo_scoreboard sb;
   bit             jitter_on = 1'b1;
   int             events_sent = 0;
   int             settings_used = 1;

   ultrasonic_echo_pulse_timer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Valid stays high across back-to-back transfers; it only drops for a gap.
   task automatic send_event(input logic [1:0] op, input logic [CAPTURE_BITS-1:0] cnt);
      int      gap;
      req_type ev;
      ev.opcode = op;
      ev.capture_count = cnt;
      gap = jitter_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= ev;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_event(ev);
      events_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_BITS-1:0] period_w,
                              input logic [CSR_DATA_BITS-1:0] range_w,
                              input logic [CSR_DATA_BITS-1:0] limit_w);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TIMER_PERIOD;
      csr_wdata <= period_w;
      @(posedge clock);
      sb.write_reg(CSR_TIMER_PERIOD, period_w);
      csr_index <= CSR_RANGE_LIMIT;
      csr_wdata <= range_w;
      @(posedge clock);
      sb.write_reg(CSR_RANGE_LIMIT, range_w);
      csr_index <= CSR_OVERFLOW_LIMIT;
      csr_wdata <= limit_w;
      @(posedge clock);
      sb.write_reg(CSR_OVERFLOW_LIMIT, limit_w);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // One rise, some overflow ticks and a fall, with a share of broken shapes:
   // timeouts, a second rise while armed and stray events in between.
   task automatic measure_pulse();
      logic [CAPTURE_BITS-1:0] rise_at;
      logic [CAPTURE_BITS-1:0] fall_at;
      int                      shape;
      int                      delta;
      int                      end_at;
      int                      ticks;
      int                      lim;
      jitter_on = ($urandom_range(0, 3) != 0);
      lim = int'(sb.ovf_limit);
      rise_at = CAPTURE_BITS'($urandom);
      fall_at = CAPTURE_BITS'($urandom);
      shape = $urandom_range(0, 9);
      ticks = $urandom_range(0, lim);
      if (shape < 6) begin
         delta = $urandom_range(0, 1) ? $urandom_range(0, 45000) : $urandom_range(0, 200000);
         end_at = int'(rise_at) + delta;
         fall_at = end_at[CAPTURE_BITS-1:0];
         ticks = end_at >> CAPTURE_BITS;
         if (ticks > lim) ticks = lim;
      end else if (shape == 8) begin
         ticks = lim + 1;
      end
      send_event(OP_RISE, rise_at);
      if (shape == 9) begin
         if ($urandom_range(0, 1)) send_event(OP_IDLE, CAPTURE_BITS'($urandom));
         send_event(OP_RISE, CAPTURE_BITS'($urandom));
      end
      repeat (ticks) send_event(OP_OVERFLOW, CAPTURE_BITS'($urandom));
      send_event(OP_FALL, fall_at);
   endtask

   task automatic run_random(input int count);
      int target;
      target = events_sent + count;
      while (events_sent < target) begin
         if ($urandom_range(0, 9) < 8) begin
            measure_pulse();
         end else begin
            jitter_on = 1'b1;
            send_event(2'($urandom_range(0, 3)), CAPTURE_BITS'($urandom));
         end
      end
   endtask

   // Result side: a random stall before each transfer.
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = jitter_on ? $urandom_range(0, 4) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: stray events, boundaries and the timeout.
      send_event(OP_IDLE, 16'hFFFF);
      send_event(OP_FALL, 16'h1234);
      send_event(OP_OVERFLOW, 16'h0000);
      send_event(OP_RISE, 16'h0000);
      send_event(OP_FALL, 16'hFFFF);
      send_event(OP_RISE, 16'd100);
      send_event(OP_FALL, 16'd100);
      send_event(OP_RISE, 16'hFFFF);
      send_event(OP_OVERFLOW, 16'hFFFF);
      send_event(OP_FALL, 16'h0000);
      send_event(OP_RISE, 16'd1000);
      send_event(OP_FALL, 16'd39000);
      send_event(OP_RISE, 16'd1000);
      send_event(OP_FALL, 16'd39001);
      send_event(OP_RISE, 16'd5);
      repeat (3) send_event(OP_OVERFLOW, 16'd0);
      send_event(OP_FALL, 16'd9);
      send_event(OP_RISE, 16'd10);
      send_event(OP_RISE, 16'd20);
      send_event(OP_OVERFLOW, 16'd0);
      send_event(OP_FALL, 16'd30);
      send_event(OP_RISE, 16'h0000);
      send_event(OP_IDLE, 16'h0000);

      // Smallest nonzero period and range limit, and overflow limit zero.
      load_config(18'd1, 18'd1, 18'd0);
      send_event(OP_FALL, 16'h0001);
      send_event(OP_RISE, 16'd0);
      send_event(OP_FALL, 16'd1);
      send_event(OP_RISE, 16'd0);
      send_event(OP_FALL, 16'd2);
      send_event(OP_RISE, 16'd5);
      send_event(OP_OVERFLOW, 16'd0);
      run_random(150);

      // Largest settings; the width wraps past 18 bits.
      load_config(18'd131071, 18'd262143, 18'd3);
      send_event(OP_RISE, 16'h0000);
      repeat (3) send_event(OP_OVERFLOW, 16'h5555);
      send_event(OP_FALL, 16'hFFFF);
      send_event(OP_RISE, 16'hFFFF);
      send_event(OP_FALL, 16'h0000);
      run_random(200);

      // A zero period makes overflow ticks add nothing.
      load_config(18'd0, 18'd262143, 18'd3);
      run_random(150);

      load_config(18'd65536, 18'd38000, 18'd2);
      run_random(250);

      repeat (4) begin
         case ($urandom_range(0, 3))
            0: load_config(CSR_DATA_BITS'($urandom_range(1, 64)),
                           CSR_DATA_BITS'($urandom_range(1, 262143)),
                           CSR_DATA_BITS'($urandom_range(0, 3)));
            1: load_config(CSR_DATA_BITS'($urandom_range(1, 65536)),
                           CSR_DATA_BITS'($urandom_range(1, 50000)),
                           CSR_DATA_BITS'($urandom_range(0, 3)));
            2: load_config(CSR_DATA_BITS'($urandom_range(0, 262143)),
                           CSR_DATA_BITS'($urandom_range(1, 262143)),
                           CSR_DATA_BITS'($urandom_range(0, 262143)));
            default: load_config(18'd65536, CSR_DATA_BITS'($urandom_range(1, 50000)),
                                 CSR_DATA_BITS'($urandom_range(0, 3)));
         endcase
         run_random(200);
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report_mismatch("results never delivered", 0, sb.pending.size());
      $display("Covered %0d events and %0d result transfers over %0d register settings.",
               events_sent, sb.checked, settings_used);
      $display("Expected status mix: none %0d, out of range %0d, valid %0d.",
               sb.status_seen[STATUS_NONE], sb.status_seen[STATUS_RANGE],
               sb.status_seen[STATUS_VALID]);
      if (sb.fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout: the run did not finish in time.");
      $display("simulation failed");
      $finish;
   end

endmodule
